[rtl/nubs_pkg.sv]
`default_nettype none

package nubs_pkg;

    localparam int unsigned DEFAULT_MAX_FRAME_BYTES = 1048576;

    localparam logic [7:0] BYTE_ZERO  = 8'h00;
    localparam logic [7:0] BYTE_SC    = 8'h01;
    localparam logic [7:0] BYTE_EMUL  = 8'h03;

    // zero run saturates here; start codes need two to seven zeros
    localparam logic [3:0] ZRUN_MAX   = 4'd8;
    localparam logic [3:0] ZRUN_SC_LO = 4'd2;
    localparam logic [3:0] ZRUN_SC_HI = 4'd7;
    localparam logic [3:0] ZRUN_EMUL  = 4'd2;

    localparam int unsigned OFFSET_W = 20;
    localparam int unsigned LENGTH_W = 21;
    localparam int unsigned EMUL_W   = 20;
    localparam int unsigned SCLEN_W  = 4;
    localparam int unsigned OUT_DATA_W = 88;

    typedef struct packed {
        logic       frame_end;
        logic [7:0] data_byte;
    } item_t;

    typedef struct packed {
        logic                frame_done;
        logic [SCLEN_W-1:0]  start_code_length;
        logic [LENGTH_W-1:0] consumed_length;
        logic [EMUL_W-1:0]   emulation_count;
        logic [LENGTH_W-1:0] payload_length;
        logic [OFFSET_W-1:0] payload_offset;
    } result_t;

endpackage

`default_nettype wire

[rtl/nubs_in_reg.sv]
`default_nettype none

module nubs_in_reg
(
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_ready,
    input  nubs_pkg::item_t     in_item,
    output logic                item_valid,
    input  wire                 item_take,
    output nubs_pkg::item_t     item
);

    logic            valid_reg;
    logic            valid_next;
    nubs_pkg::item_t item_reg;

    // take a new request whenever the held one is empty or leaves this cycle
    assign in_ready   = !valid_reg || item_take;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

[rtl/nubs_core.sv]
`default_nettype none

module nubs_core
#(
    parameter int unsigned MAX_FRAME_BYTES = nubs_pkg::DEFAULT_MAX_FRAME_BYTES
)
(
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 item_valid,
    output logic                item_take,
    input  nubs_pkg::item_t     item,
    output logic                res_valid,
    input  wire                 res_ready,
    output nubs_pkg::result_t   res
);

    localparam int unsigned CNT_W = $clog2(MAX_FRAME_BYTES + 1);
    localparam int unsigned EXT_W = (CNT_W > nubs_pkg::LENGTH_W) ? CNT_W : nubs_pkg::LENGTH_W;
    localparam logic [EXT_W-1:0] MAX20 = EXT_W'((1 << 20) - 1);
    localparam logic [EXT_W-1:0] MAX21 = EXT_W'((1 << 21) - 1);
    localparam logic [CNT_W-1:0] LAST_POS = CNT_W'(MAX_FRAME_BYTES - 1);

    function automatic logic [19:0] sat20(input logic [CNT_W-1:0] v);
        logic [EXT_W-1:0] e;
        e = EXT_W'(v);
        sat20 = (e > MAX20) ? 20'hFFFFF : e[19:0];
    endfunction

    function automatic logic [20:0] sat21(input logic [CNT_W-1:0] v);
        logic [EXT_W-1:0] e;
        e = EXT_W'(v);
        sat21 = (e > MAX21) ? 21'h1FFFFF : e[20:0];
    endfunction

    logic             in_prefix_reg,  in_prefix_next;
    logic [3:0]       zero_run_reg,   zero_run_next;
    logic [CNT_W-1:0] frame_pos_reg,  frame_pos_next;
    logic [CNT_W-1:0] unit_start_reg, unit_start_next;
    logic [CNT_W-1:0] raw_cnt_reg,    raw_cnt_next;
    logic [CNT_W-1:0] emul_cnt_reg,   emul_cnt_next;
    logic [CNT_W-1:0] prefix_cnt_reg, prefix_cnt_next;

    logic              res_valid_reg, res_valid_next;
    nubs_pkg::result_t res_reg;

    logic             emit;
    logic [CNT_W-1:0] e_off, e_len, e_emu, e_cons;
    logic [3:0]       e_sc;
    logic             e_done;

    logic             fe;
    logic [CNT_W-1:0] pos;
    logic [CNT_W-1:0] raw1;
    logic [CNT_W-1:0] prefix1;
    logic [CNT_W-1:0] emul1;
    logic [CNT_W-1:0] sc_w;
    logic [3:0]       sc;
    logic [7:0]       b;
    logic             is_emul;
    logic             is_sc;

    assign item_take = item_valid && (!res_valid_reg || res_ready);

    always_comb
    begin
        b       = item.data_byte;
        fe      = item.frame_end || (frame_pos_reg == LAST_POS);
        pos     = frame_pos_reg + CNT_W'(1);
        raw1    = raw_cnt_reg + CNT_W'(1);
        prefix1 = prefix_cnt_reg + CNT_W'(1);
        emul1   = emul_cnt_reg + CNT_W'(1);
        sc      = zero_run_reg + 4'd1;
        sc_w    = CNT_W'(sc);
        is_emul = (zero_run_reg == nubs_pkg::ZRUN_EMUL) && (b == nubs_pkg::BYTE_EMUL);
        is_sc   = (zero_run_reg >= nubs_pkg::ZRUN_SC_LO) && (zero_run_reg <= nubs_pkg::ZRUN_SC_HI)
                  && (b == nubs_pkg::BYTE_SC);

        in_prefix_next  = in_prefix_reg;
        zero_run_next   = zero_run_reg;
        frame_pos_next  = frame_pos_reg;
        unit_start_next = unit_start_reg;
        raw_cnt_next    = raw_cnt_reg;
        emul_cnt_next   = emul_cnt_reg;
        prefix_cnt_next = prefix_cnt_reg;

        emit   = 1'b0;
        e_off  = unit_start_reg;
        e_len  = '0;
        e_emu  = emul_cnt_reg;
        e_cons = '0;
        e_sc   = 4'd0;
        e_done = 1'b1;

        if (in_prefix_reg)
        begin
            prefix_cnt_next = prefix1;
            if (b != nubs_pkg::BYTE_ZERO)
            begin
                in_prefix_next  = 1'b0;
                unit_start_next = pos;
                zero_run_next   = 4'd0;
                raw_cnt_next    = '0;
                emul_cnt_next   = '0;
            end
            frame_pos_next = pos;
            if (fe)
            begin
                emit   = 1'b1;
                e_off  = pos;
                e_emu  = '0;
                e_cons = prefix1;
            end
        end
        else if (is_sc)
        begin
            // start code closes the unit; its bytes become the next prefix
            emit   = 1'b1;
            e_len  = raw1 - sc_w - emul_cnt_reg;
            e_cons = prefix_cnt_reg + raw1 - sc_w;
            e_sc   = sc;
            e_done = fe;
            prefix_cnt_next = sc_w;
            unit_start_next = pos;
            raw_cnt_next    = '0;
            emul_cnt_next   = '0;
            zero_run_next   = 4'd0;
            frame_pos_next  = pos;
        end
        else
        begin
            raw_cnt_next   = raw1;
            frame_pos_next = pos;
            if (is_emul)
            begin
                emul_cnt_next = emul1;
                zero_run_next = 4'd0;
            end
            else if (b == nubs_pkg::BYTE_ZERO)
            begin
                if (zero_run_reg < nubs_pkg::ZRUN_MAX)
                begin
                    zero_run_next = zero_run_reg + 4'd1;
                end
            end
            else
            begin
                zero_run_next = 4'd0;
            end
            if (fe)
            begin
                emit   = 1'b1;
                e_len  = raw1 - emul_cnt_next;
                e_emu  = emul_cnt_next;
                e_cons = prefix_cnt_reg + raw1;
            end
        end

        // frame end: clear for the next frame
        if (fe)
        begin
            in_prefix_next  = 1'b1;
            zero_run_next   = 4'd0;
            frame_pos_next  = '0;
            unit_start_next = '0;
            raw_cnt_next    = '0;
            emul_cnt_next   = '0;
            prefix_cnt_next = '0;
        end

        if (item_take)
        begin
            res_valid_next = emit;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_prefix_reg  <= 1'b1;
            zero_run_reg   <= 4'd0;
            frame_pos_reg  <= '0;
            unit_start_reg <= '0;
            raw_cnt_reg    <= '0;
            emul_cnt_reg   <= '0;
            prefix_cnt_reg <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (item_take)
            begin
                in_prefix_reg  <= in_prefix_next;
                zero_run_reg   <= zero_run_next;
                frame_pos_reg  <= frame_pos_next;
                unit_start_reg <= unit_start_next;
                raw_cnt_reg    <= raw_cnt_next;
                emul_cnt_reg   <= emul_cnt_next;
                prefix_cnt_reg <= prefix_cnt_next;
            end
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take && emit)
        begin
            res_reg.payload_offset    <= sat20(e_off);
            res_reg.payload_length    <= sat21(e_len);
            res_reg.emulation_count   <= sat20(e_emu);
            res_reg.consumed_length   <= sat21(e_cons);
            res_reg.start_code_length <= e_sc;
            res_reg.frame_done        <= e_done;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire

[rtl/nal_unit_boundary_scanner.sv]
// Channel  Direction  Handshake            Payload
// s_       in         s_tvalid / s_tready  s_tdata: data_byte; s_tlast: frame_end
// m_       out        m_tvalid / m_tready  m_tdata: unit descriptor; m_tlast: frame_done
//
// One byte per cycle while descriptors are taken; a unit's last byte passes the
// input register, then scan logic puts its descriptor in the result register.
// rst_n clears the scan state to the start of a frame and empties both registers.
// A held descriptor stalls the scan stage only; the input register still fills.
`default_nettype none

module nal_unit_boundary_scanner
#(
    parameter int unsigned MAX_FRAME_BYTES = nubs_pkg::DEFAULT_MAX_FRAME_BYTES
)
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,   // [7:0] data_byte
    input  wire         s_tlast,
    output logic        m_tvalid,
    input  wire         m_tready,
    // [19:0] payload_offset, [40:20] payload_length, [60:41] emulation_count,
    // [81:61] consumed_length, [85:82] start_code_length, [87:86] zero
    output logic [nubs_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic        m_tlast
);

    nubs_pkg::item_t   in_item;
    nubs_pkg::item_t   item;
    nubs_pkg::result_t res;
    logic              item_valid;
    logic              item_take;

    assign in_item.data_byte = s_tdata;
    assign in_item.frame_end = s_tlast;

    nubs_in_reg u_in_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item_take  (item_take),
        .item       (item)
    );

    nubs_core #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_take  (item_take),
        .item       (item),
        .res_valid  (m_tvalid),
        .res_ready  (m_tready),
        .res        (res)
    );

    assign m_tdata = {2'b00, res.start_code_length, res.consumed_length,
                      res.emulation_count, res.payload_length, res.payload_offset};
    assign m_tlast = res.frame_done;

endmodule

`default_nettype wire

[tb/nal_unit_boundary_scanner_tb.sv]
`default_nettype none

module nal_unit_boundary_scanner_tb;

    timeunit 1ns;
    timeprecision 1ps;

    // frame limit the scanner is built with
    localparam int unsigned MAX_FRAME    = 1024;
    localparam int unsigned RANDOM_BYTES = 400;

    typedef struct {
        logic [7:0]          data;
        logic                last;
        bit                  typed;
        nubs_pkg::result_t   unit;
    } stim_row_t;

    logic                            clk;
    logic                            rst_n;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [7:0]                      s_tdata;
    logic                            s_tlast;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [nubs_pkg::OUT_DATA_W-1:0] m_tdata;
    logic                            m_tlast;

    // scanner state as seen by the predictor
    bit          scan_in_prefix;
    logic [3:0]  scan_zrun;
    int unsigned scan_pos;
    int unsigned scan_unit_start;
    int unsigned scan_raw;
    int unsigned scan_emul;
    int unsigned scan_prefix_cnt;

    nubs_pkg::result_t pending_units[$];
    stim_row_t         dir_table[$];
    bit          src_idle;
    bit          snk_idle;
    int unsigned mismatches;
    int unsigned bytes_sent;
    int unsigned units_checked;
    int unsigned sc_units;
    int unsigned emul_total;
    int unsigned frames_done;

    nal_unit_boundary_scanner #(
        .MAX_FRAME_BYTES(MAX_FRAME)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic nubs_pkg::result_t make_unit(input int unsigned off,
                                                    input int unsigned len,
                                                    input int unsigned emu,
                                                    input int unsigned cons,
                                                    input int unsigned sc, input bit done);
        nubs_pkg::result_t u;
        u.payload_offset    = off[nubs_pkg::OFFSET_W-1:0];
        u.payload_length    = len[nubs_pkg::LENGTH_W-1:0];
        u.emulation_count   = emu[nubs_pkg::EMUL_W-1:0];
        u.consumed_length   = cons[nubs_pkg::LENGTH_W-1:0];
        u.start_code_length = sc[nubs_pkg::SCLEN_W-1:0];
        u.frame_done        = done;
        return u;
    endfunction

    task automatic scan_restart();
        scan_in_prefix  = 1'b1;
        scan_zrun       = '0;
        scan_pos        = 0;
        scan_unit_start = 0;
        scan_raw        = 0;
        scan_emul       = 0;
        scan_prefix_cnt = 0;
    endtask

    // advance the scanner by one byte; have is set when a unit closes
    task automatic scan_byte(input logic [7:0] b, input logic l,
                             output bit have, output nubs_pkg::result_t u);
        bit          fe;
        int unsigned pos;
        int unsigned sc;
        have = 1'b0;
        u    = '0;
        fe   = l || (scan_pos + 1 >= MAX_FRAME);
        pos  = scan_pos + 1;
        if (scan_in_prefix)
        begin
            scan_prefix_cnt++;
            if (b != nubs_pkg::BYTE_ZERO)
            begin
                scan_in_prefix  = 1'b0;
                scan_unit_start = pos;
                scan_zrun       = '0;
                scan_raw        = 0;
                scan_emul       = 0;
            end
            if (fe)
            begin
                have = 1'b1;
                u = make_unit(pos, 0, 0, scan_prefix_cnt, 0, 1'b1);
                scan_restart();
            end
            else
                scan_pos = pos;
            return;
        end
        scan_raw++;
        if (scan_zrun == nubs_pkg::ZRUN_EMUL && b == nubs_pkg::BYTE_EMUL)
        begin
            scan_emul++;
            scan_zrun = '0;
        end
        else if (scan_zrun >= nubs_pkg::ZRUN_SC_LO && scan_zrun <= nubs_pkg::ZRUN_SC_HI
                 && b == nubs_pkg::BYTE_SC)
        begin
            sc   = scan_zrun + 1;
            have = 1'b1;
            u = make_unit(scan_unit_start, scan_raw - sc - scan_emul, scan_emul,
                          scan_prefix_cnt + scan_raw - sc, sc, fe);
            if (fe)
                scan_restart();
            else
            begin
                // start code becomes the prefix of the next unit
                scan_prefix_cnt = sc;
                scan_unit_start = pos;
                scan_raw        = 0;
                scan_emul       = 0;
                scan_zrun       = '0;
                scan_pos        = pos;
            end
            return;
        end
        else if (b == nubs_pkg::BYTE_ZERO)
        begin
            if (scan_zrun < nubs_pkg::ZRUN_MAX)
                scan_zrun++;
        end
        else
            scan_zrun = '0;
        if (fe)
        begin
            have = 1'b1;
            u = make_unit(scan_unit_start, scan_raw - scan_emul, scan_emul,
                          scan_prefix_cnt + scan_raw, 0, 1'b1);
            scan_restart();
        end
        else
            scan_pos = pos;
    endtask

    // called at a falling edge, returns at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic l,
                             input bit typed, input nubs_pkg::result_t typed_unit);
        int                gap;
        bit                have;
        nubs_pkg::result_t u;
        gap = src_idle ? $urandom_range(0, 4) : 0;
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = b;
        s_tlast  = l;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        scan_byte(b, l, have, u);
        if (have)
            pending_units.push_back(typed ? typed_unit : u);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic add_row(input logic [7:0] b, input logic l);
        stim_row_t r;
        r.data  = b;
        r.last  = l;
        r.typed = 1'b0;
        r.unit  = '0;
        dir_table.push_back(r);
    endtask

    task automatic wait_drained();
        while (pending_units.size() != 0)
            @(negedge clk);
    endtask

    // build one frame of roughly n bytes, mostly well formed, then send it
    task automatic play_frame(input int unsigned n);
        logic [7:0] bq[$];
        int         r;
        int         z;
        if ($urandom_range(0, 9) == 0)
        begin
            // frame that never leaves the zero prefix
            repeat ($urandom_range(1, 4)) bq.push_back(nubs_pkg::BYTE_ZERO);
        end
        else
        begin
            repeat ($urandom_range(0, 4)) bq.push_back(nubs_pkg::BYTE_ZERO);
            bq.push_back($urandom_range(0, 2) != 0 ? nubs_pkg::BYTE_SC
                                                   : 8'($urandom_range(1, 255)));
            while (bq.size() < n)
            begin
                r = $urandom_range(0, 9);
                if (r < 2)
                begin
                    repeat ($urandom_range(2, 7)) bq.push_back(nubs_pkg::BYTE_ZERO);
                    bq.push_back(nubs_pkg::BYTE_SC);
                end
                else if (r == 2)
                begin
                    bq.push_back(nubs_pkg::BYTE_ZERO);
                    bq.push_back(nubs_pkg::BYTE_ZERO);
                    bq.push_back(nubs_pkg::BYTE_EMUL);
                end
                else if (r < 5)
                begin
                    // zero runs around and past the start-code window
                    z = (r == 3) ? $urandom_range(8, 10) : $urandom_range(0, 3);
                    repeat (z) bq.push_back(nubs_pkg::BYTE_ZERO);
                    case ($urandom_range(0, 2))
                        0:       bq.push_back(nubs_pkg::BYTE_SC);
                        1:       bq.push_back(nubs_pkg::BYTE_EMUL);
                        default: bq.push_back(8'($urandom_range(0, 255)));
                    endcase
                end
                else
                    bq.push_back($urandom_range(0, 9) < 3 ? nubs_pkg::BYTE_ZERO
                                                         : 8'($urandom_range(0, 255)));
            end
        end
        foreach (bq[i])
            send_byte(bq[i], i == bq.size() - 1, 1'b0, '0);
    endtask

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
        if (exp_v != act_v)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, exp_v, act_v);
        end
    endtask

    // result side: random stall before each descriptor, then check it
    initial
    begin
        int                stall;
        nubs_pkg::result_t exp_u;
        m_tready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = snk_idle ? $urandom_range(0, 4) : 0;
            if (stall > 0)
            begin
                m_tready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready = 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            if (pending_units.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected descriptor %h last %b", $realtime, m_tdata, m_tlast);
            end
            else
            begin
                exp_u = pending_units.pop_front();
                check_field("payload_offset", exp_u.payload_offset, m_tdata[19:0]);
                check_field("payload_length", exp_u.payload_length, m_tdata[40:20]);
                check_field("emulation_count", exp_u.emulation_count, m_tdata[60:41]);
                check_field("consumed_length", exp_u.consumed_length, m_tdata[81:61]);
                check_field("start_code_length", exp_u.start_code_length, m_tdata[85:82]);
                check_field("pad_bits", 0, m_tdata[87:86]);
                check_field("frame_done", exp_u.frame_done, m_tlast);
                units_checked++;
                if (exp_u.start_code_length != 0)
                    sc_units++;
                emul_total += exp_u.emulation_count;
                if (exp_u.frame_done)
                    frames_done++;
            end
            @(negedge clk);
        end
    end

    initial
    begin
        int  sent_random;
        clk      = 1'b0;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        src_idle = 1'b1;
        snk_idle = 1'b1;
        mismatches    = 0;
        bytes_sent    = 0;
        units_checked = 0;
        sc_units      = 0;
        emul_total    = 0;
        frames_done   = 0;
        scan_restart();

        // frame that ends inside the zero prefix
        add_row(nubs_pkg::BYTE_ZERO, 1'b1);
        dir_table[0].typed = 1'b1;
        dir_table[0].unit  = make_unit(1, 0, 0, 1, 0, 1'b1);
        // one-byte prefix, all-ones byte, emulation byte, three zeros before 0x03
        add_row(nubs_pkg::BYTE_SC, 1'b0);
        add_row(8'hFF, 1'b0);
        add_row(nubs_pkg::BYTE_ZERO, 1'b0);
        add_row(nubs_pkg::BYTE_ZERO, 1'b0);
        add_row(nubs_pkg::BYTE_EMUL, 1'b0);
        add_row(nubs_pkg::BYTE_ZERO, 1'b0);
        add_row(nubs_pkg::BYTE_ZERO, 1'b0);
        add_row(nubs_pkg::BYTE_ZERO, 1'b0);
        add_row(nubs_pkg::BYTE_EMUL, 1'b0);
        // longest start code: seven zeros then 0x01
        repeat (7) add_row(nubs_pkg::BYTE_ZERO, 1'b0);
        add_row(nubs_pkg::BYTE_SC, 1'b0);
        // shortest start code on the last byte of the frame
        add_row(nubs_pkg::BYTE_ZERO, 1'b0);
        add_row(nubs_pkg::BYTE_ZERO, 1'b0);
        add_row(nubs_pkg::BYTE_SC, 1'b1);

        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (dir_table[i])
            send_byte(dir_table[i].data, dir_table[i].last, dir_table[i].typed,
                      dir_table[i].unit);
        s_tvalid = 1'b0;
        // hold off until every descriptor so far has been returned
        wait_drained();

        sent_random = 0;
        while (sent_random < RANDOM_BYTES)
        begin
            src_idle = $urandom_range(0, 3) != 0;
            snk_idle = $urandom_range(0, 3) != 0;
            sent_random -= bytes_sent;
            play_frame($urandom_range(1, 40));
            sent_random += bytes_sent;
        end
        s_tvalid = 1'b0;
        src_idle = 1'b0;

        wait_drained();
        repeat (20) @(posedge clk);
        $display("sent %0d bytes; checked %0d units (%0d closed by start code, %0d frame ends)",
                 bytes_sent, units_checked, sc_units, frames_done);
        $display("emulation bytes counted: %0d, over short random frames with random stalls",
                 emul_total);
        if (mismatches == 0 && pending_units.size() == 0)
            $display("nal_unit_boundary_scanner_tb: clean");
        else
            $display("nal_unit_boundary_scanner_tb: errors");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("timeout waiting for the scanner");
        $display("nal_unit_boundary_scanner_tb: errors");
        $finish;
    end

endmodule

`default_nettype wire

[filelist.f]
rtl/nubs_pkg.sv
rtl/nubs_in_reg.sv
rtl/nubs_core.sv
rtl/nal_unit_boundary_scanner.sv
tb/nal_unit_boundary_scanner_tb.sv
